// File: hdl/pat_pkg.sv
// Shared constants, types and a helper function of the page arrival state tracker.
package pat_pkg;

   // Map geometry.
   localparam int PAGE_COUNT = 65536;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int MAP_AW     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int SIZE_W     = BIT_W + 1;

   // Field widths of the channels.
   localparam int PAGE_W     = 16;
   localparam int CNT_W      = 17;
   localparam int SUM_W      = CNT_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [MAP_AW-1:0]    waddr_type;
   typedef logic [PAGE_W-1:0]    page_type;

   // Operation codes.
   localparam logic [1:0] OP_GET     = 2'd0;
   localparam logic [1:0] OP_CHANGE  = 2'd1;
   localparam logic [1:0] OP_DISCARD = 2'd2;
   localparam logic [1:0] OP_EARLY   = 2'd3;

   // Page group states.
   localparam logic [1:0] ST_MISSING   = 2'd0;
   localparam logic [1:0] ST_REQUESTED = 2'd1;
   localparam logic [1:0] ST_RECEIVED  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_MISALIGNED = 2'd1;
   localparam logic [1:0] STAT_PARTIAL    = 2'd2;
   localparam logic [1:0] STAT_ILLEGAL    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADVISE_MODE = 2'd1;

   // Map word that holds a given small page.
   function automatic waddr_type page_word(input page_type page);
      page_word = MAP_AW'(page >> BIT_W);
   endfunction

endpackage

// File: hdl/pat_channels.sv
// Handshake channel interfaces of the page arrival state tracker.
interface pat_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic [pat_pkg::PAGE_W-1:0] page_index;
   logic [1:0]                match_state;
   logic [1:0]                target_state;
   logic [pat_pkg::CNT_W-1:0] page_count;

   modport source (output valid, opcode, page_index, match_state, target_state, page_count,
                   input ready);
   modport sink   (input valid, opcode, page_index, match_state, target_state, page_count,
                   output ready);
endinterface

interface pat_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] prior_state;
   logic [1:0] status;

   modport source (output valid, prior_state, status, input ready);
   modport sink   (input valid, prior_state, status, output ready);
endinterface

interface pat_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pat_pkg::CSR_IDX_W-1:0]  index;
   logic [pat_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/page_arrival_state_tracker.sv
// Top level of the page arrival state tracker: bit maps, sequencer and result register.
//
// The block keeps a received map and a requested map, one bit per small page,
// each held in a synchronous memory of MAP_WORDS words. Items arrive on req_if:
// get state, change state, discard range and early receive. Every item gives
// exactly one result on rsp_if with the group's old state and a status code.
// Registers group_shift and advise_mode are written through csr_if, which is
// always ready.
// Single-page items read the map word at acceptance; in the modify state that
// follows, once the output register is free, the word is modified and written
// back and the result is loaded. A discard walks the map words of its range;
// each word is read, then modified and written back.
// The result sits in an output register; while it waits for rsp_if.ready the
// block still accepts a new item and stalls only when it must load the next
// result while the previous one is still held.
// After reset both maps are cleared by a pass over all MAP_WORDS words, one
// word per cycle; no item is accepted during the pass, while configuration
// writes are taken.
module page_arrival_state_tracker (
   input logic       clock,
   input logic       reset,
   pat_req_if.sink   req_if,
   pat_rsp_if.source rsp_if,
   pat_csr_if.sink   csr_if
);

   // Sequencer states.
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_DREAD = 2'd3;

   localparam pat_pkg::word_type WORD_ONES = '1;
   localparam pat_pkg::word_type WORD_ONE  = pat_pkg::word_type'(1);

   // The two bit maps.
   pat_pkg::word_type rec_mem [pat_pkg::MAP_WORDS];
   pat_pkg::word_type req_mem [pat_pkg::MAP_WORDS];

   // Control and item registers.
   logic [1:0]         state_ff, state_in;
   pat_pkg::waddr_type clr_ff, clr_in;
   pat_pkg::waddr_type cur_ff, cur_in;
   logic [1:0]         op_ff, op_in;
   pat_pkg::page_type  idx_ff, idx_in;
   pat_pkg::page_type  last_ff, last_in;
   logic               empty_ff, empty_in;
   logic [1:0]         exp_ff, exp_in;
   logic [1:0]         new_ff, new_in;
   logic [2:0]         shift_ff;
   logic               advise_ff;
   pat_pkg::word_type  rec_rd_ff, req_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_old_ff, rsp_old_in;
   logic [1:0]         rsp_stat_ff, rsp_stat_in;

   // Memory access signals.
   logic               rd_en;
   pat_pkg::waddr_type rd_addr;
   pat_pkg::waddr_type wr_addr;
   logic               rec_we, req_we;
   pat_pkg::word_type  rec_wdata, req_wdata;

   // Item decode and group evaluation.
   logic                        accept;
   logic                        out_free;
   logic [pat_pkg::SUM_W-1:0]   range_end;
   logic [pat_pkg::SUM_W-1:0]   range_clip;
   logic [2:0]                  shift_sat;
   logic [pat_pkg::SIZE_W-1:0]  grp_size;
   pat_pkg::word_type           gmask;
   logic                        misaligned;
   pat_pkg::word_type           rec_g, req_g;
   logic                        rc_none, rc_all, rq_none, rq_all;
   logic                        partial;
   logic [1:0]                  grp_old;
   logic [pat_pkg::BIT_W-1:0]   dlo, dhi;
   pat_pkg::word_type           dmask;
   logic                        last_word;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready  = 1'b1;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.prior_state = rsp_old_ff;
   assign rsp_if.status      = rsp_stat_ff;

   // Discard range end, clipped at the map end.
   assign range_end  = pat_pkg::SUM_W'(req_if.page_index) + pat_pkg::SUM_W'(req_if.page_count);
   assign range_clip = (range_end > pat_pkg::SUM_W'(pat_pkg::PAGE_COUNT)) ?
                       pat_pkg::SUM_W'(pat_pkg::PAGE_COUNT) : range_end;

   // Group size saturates at one map word.
   assign shift_sat  = (shift_ff > 3'(pat_pkg::BIT_W)) ? 3'(pat_pkg::BIT_W) : shift_ff;
   assign grp_size   = pat_pkg::SIZE_W'(1) << shift_sat;
   assign gmask      = (WORD_ONES >> (pat_pkg::SIZE_W'(pat_pkg::WORD_BITS) - grp_size))
                       << idx_ff[pat_pkg::BIT_W-1:0];
   assign misaligned = (idx_ff[pat_pkg::BIT_W-1:0] &
                        pat_pkg::BIT_W'(grp_size - pat_pkg::SIZE_W'(1))) != '0;

   // Group state from the two map words.
   assign rec_g   = rec_rd_ff & gmask;
   assign req_g   = req_rd_ff & gmask;
   assign rc_none = (rec_g == '0);
   assign rc_all  = (rec_g == gmask);
   assign rq_none = (req_g == '0);
   assign rq_all  = (req_g == gmask);
   assign partial = (!rc_none && !rc_all) || (!rq_none && !rq_all) || (rc_all && rq_all);
   assign grp_old = rc_all ? pat_pkg::ST_RECEIVED :
                    (rq_all ? pat_pkg::ST_REQUESTED : pat_pkg::ST_MISSING);

   // Bits of the current discard word that fall inside the range.
   assign dlo       = (cur_ff == pat_pkg::page_word(idx_ff)) ? idx_ff[pat_pkg::BIT_W-1:0] : '0;
   assign dhi       = (cur_ff == pat_pkg::page_word(last_ff)) ? last_ff[pat_pkg::BIT_W-1:0] : '1;
   assign dmask     = (WORD_ONES << dlo) & (WORD_ONES >> (~dhi));
   assign last_word = empty_ff || (cur_ff == pat_pkg::page_word(last_ff));

   // Sequencer and read-modify-write logic.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      exp_in       = exp_ff;
      new_in       = new_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_old_in   = rsp_old_ff;
      rsp_stat_in  = rsp_stat_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      wr_addr      = cur_ff;
      rec_we       = 1'b0;
      req_we       = 1'b0;
      rec_wdata    = rec_rd_ff;
      req_wdata    = req_rd_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_addr   = clr_ff;
            rec_we    = 1'b1;
            req_we    = 1'b1;
            rec_wdata = '0;
            req_wdata = '0;
            clr_in    = clr_ff + pat_pkg::waddr_type'(1);
            if (clr_ff == pat_pkg::waddr_type'(pat_pkg::MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rd_en    = 1'b1;
               rd_addr  = pat_pkg::page_word(req_if.page_index);
               cur_in   = pat_pkg::page_word(req_if.page_index);
               op_in    = req_if.opcode;
               idx_in   = req_if.page_index;
               exp_in   = req_if.match_state;
               new_in   = req_if.target_state;
               last_in  = pat_pkg::page_type'(range_clip - pat_pkg::SUM_W'(1));
               empty_in = (req_if.page_count == '0);
               state_in = S_EXEC;
            end
         end
         S_DREAD: begin
            rd_en    = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == pat_pkg::OP_DISCARD) begin
               // One word of the range; the result goes out after the last one.
               if (!last_word || out_free) begin
                  rec_we    = !empty_ff;
                  rec_wdata = rec_rd_ff & ~dmask;
                  if (last_word) begin
                     rsp_valid_in = 1'b1;
                     rsp_old_in   = pat_pkg::ST_MISSING;
                     rsp_stat_in  = pat_pkg::STAT_OK;
                     state_in     = S_IDLE;
                  end else begin
                     cur_in   = cur_ff + pat_pkg::waddr_type'(1);
                     state_in = S_DREAD;
                  end
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_old_in   = pat_pkg::ST_MISSING;
               rsp_stat_in  = pat_pkg::STAT_OK;
               state_in     = S_IDLE;
               if (op_ff == pat_pkg::OP_EARLY) begin
                  rec_we    = advise_ff;
                  rec_wdata = rec_rd_ff | (WORD_ONE << idx_ff[pat_pkg::BIT_W-1:0]);
               end else if (misaligned) begin
                  rsp_stat_in = pat_pkg::STAT_MISALIGNED;
               end else if (partial) begin
                  rsp_stat_in = pat_pkg::STAT_PARTIAL;
               end else begin
                  rsp_old_in = grp_old;
                  if (op_ff == pat_pkg::OP_CHANGE && grp_old == exp_ff) begin
                     if (new_ff == pat_pkg::ST_REQUESTED && grp_old == pat_pkg::ST_MISSING) begin
                        req_we    = 1'b1;
                        req_wdata = req_rd_ff | gmask;
                     end else if (new_ff == pat_pkg::ST_RECEIVED &&
                                  grp_old != pat_pkg::ST_RECEIVED) begin
                        rec_we    = 1'b1;
                        rec_wdata = rec_rd_ff | gmask;
                        req_we    = 1'b1;
                        req_wdata = req_rd_ff & ~gmask;
                     end else begin
                        rsp_stat_in = pat_pkg::STAT_ILLEGAL;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Map memories with registered read data.
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[wr_addr] <= rec_wdata;
      end
      if (req_we) begin
         req_mem[wr_addr] <= req_wdata;
      end
      if (rd_en) begin
         rec_rd_ff <= rec_mem[rd_addr];
         req_rd_ff <= req_mem[rd_addr];
      end
   end

   // Item payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
      exp_ff      <= exp_in;
      new_ff      <= new_in;
      rsp_old_ff  <= rsp_old_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= '0;
         advise_ff <= 1'b0;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            pat_pkg::CSR_GROUP_SHIFT: shift_ff  <= csr_if.data[2:0];
            pat_pkg::CSR_ADVISE_MODE: advise_ff <= csr_if.data[0];
            default: begin
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   // An accepted item goes straight to its first modify cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> state_ff == S_EXEC)
      else $error("accepted item did not enter the modify cycle");

   // A single-page item with a free output register delivers its result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff != pat_pkg::OP_DISCARD && out_free) |=>
      (rsp_valid_ff && state_ff == S_IDLE))
      else $error("single-page item did not complete");

   // The maps are never written while the block waits for an item or a discard read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DREAD) |-> (!rec_we && !req_we))
      else $error("map write outside a modify or clear cycle");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the page arrival state tracker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Register index that selects no register; a write there must change nothing.
   localparam logic [pat_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Which predicted map a page bit belongs to.
   localparam int MAP_RCV = 0;
   localparam int MAP_RQS = 1;

   // How many bits of a group are set in one map.
   localparam logic [1:0] FILL_NONE = 2'd0;
   localparam logic [1:0] FILL_ALL  = 2'd1;
   localparam logic [1:0] FILL_SOME = 2'd2;

   // Slowest correct run: the clearing pass, about 950 items with sender gaps and
   // receiver stalls, the long hold-off and a handful of whole-map discards stay
   // well under this limit.
   localparam int CYCLE_LIMIT = 500000;

   // Register settings of the random phases; the third runs with no idling.
   localparam int PHASES = 8;
   localparam int SHIFT_PLAN [PHASES] = '{0, 7, 6, 3, 1, 5, 2, 4};
   localparam int ADVISE_PLAN [PHASES] = '{1, 1, 0, 1, 0, 1, 1, 0};
   localparam int QUIET_PHASE = 2;
   localparam int ITEMS_PER_PHASE = 110;

   typedef struct packed {
      logic [1:0]                opcode;
      pat_pkg::page_type         page_index;
      logic [1:0]                match_state;
      logic [1:0]                target_state;
      logic [pat_pkg::CNT_W-1:0] page_count;
   } page_req_type;

   typedef struct packed {
      logic [1:0] prior_state;
      logic [1:0] status;
   } page_rsp_type;

   logic clock;
   logic reset;

   pat_req_if req_ch ();
   pat_rsp_if rsp_ch ();
   pat_csr_if csr_ch ();

   page_arrival_state_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Predicted maps and registers.
   bit          page_map [2][pat_pkg::PAGE_COUNT];
   logic [2:0]  grp_shift;
   logic        advise_on;

   page_rsp_type replies_due [$];
   int          mismatch_count;
   int          items_sent;
   int          results_seen;
   int          csr_writes;
   int          cycle_count;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          hold_left;
   int unsigned hot_base;

   // Clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                  replies_due.size());
         $display("[page_arrival_state_tracker] ERROR");
         $finish;
      end
   end

   // Result ready: a long hold-off when asked, else random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at result %0d: %s is %0d, expected %0d", results_seen, what, got,
               want);
   endtask

   // Compare each accepted result with the oldest outstanding prediction.
   always @(posedge clock) begin
      page_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (replies_due.size() == 0) begin
            report_mismatch("result with no item outstanding, status", rsp_ch.status, 0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_ch.prior_state !== want.prior_state)
               report_mismatch("prior_state", rsp_ch.prior_state, want.prior_state);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
         end
      end
   end

   // Pages per group, with the shift saturated so a group fits in one map word.
   function automatic int unsigned group_pages();
      return 1 << ((grp_shift > pat_pkg::BIT_W) ? pat_pkg::BIT_W : grp_shift);
   endfunction

   function automatic logic [1:0] group_fill(input int which, input int unsigned base,
                                             input int unsigned n);
      int unsigned ones;
      ones = 0;
      for (int unsigned k = 0; k < n; k++)
         ones += page_map[which][base + k];
      if (ones == 0)
         return FILL_NONE;
      return (ones == n) ? FILL_ALL : FILL_SOME;
   endfunction

   function automatic void fill_group(input int which, input int unsigned base,
                                      input int unsigned n, input bit v);
      for (int unsigned k = 0; k < n; k++)
         page_map[which][base + k] = v;
   endfunction

   // State of an aligned group, or the partly set status.
   function automatic void read_group(input int unsigned base, input int unsigned n,
                                      output logic [1:0] st, output logic [1:0] stat);
      logic [1:0] rc;
      logic [1:0] rq;
      rc = group_fill(MAP_RCV, base, n);
      rq = group_fill(MAP_RQS, base, n);
      st = pat_pkg::ST_MISSING;
      stat = pat_pkg::STAT_OK;
      if (rc == FILL_SOME || rq == FILL_SOME || (rc == FILL_ALL && rq == FILL_ALL))
         stat = pat_pkg::STAT_PARTIAL;
      else if (rc == FILL_ALL)
         st = pat_pkg::ST_RECEIVED;
      else if (rq == FILL_ALL)
         st = pat_pkg::ST_REQUESTED;
   endfunction

   // Apply one item to the predicted maps and return the result it must give.
   function automatic page_rsp_type track_page_item(input page_req_type it);
      page_rsp_type r;
      int unsigned  n;
      int unsigned  stop;
      int unsigned  p;
      logic [1:0]   st;
      logic [1:0]   stat;
      r.prior_state = pat_pkg::ST_MISSING;
      r.status = pat_pkg::STAT_OK;
      n = group_pages();
      case (it.opcode) inside
         pat_pkg::OP_GET, pat_pkg::OP_CHANGE: begin
            if ((it.page_index & (n - 1)) != 0) begin
               r.status = pat_pkg::STAT_MISALIGNED;
            end else begin
               read_group(it.page_index, n, st, stat);
               r.status = stat;
               r.prior_state = st;
               if (stat == pat_pkg::STAT_OK && it.opcode == pat_pkg::OP_CHANGE &&
                   st == it.match_state) begin
                  if (it.target_state == pat_pkg::ST_REQUESTED &&
                      st == pat_pkg::ST_MISSING) begin
                     fill_group(MAP_RQS, it.page_index, n, 1'b1);
                  end else if (it.target_state == pat_pkg::ST_RECEIVED &&
                               st != pat_pkg::ST_RECEIVED) begin
                     fill_group(MAP_RCV, it.page_index, n, 1'b1);
                     fill_group(MAP_RQS, it.page_index, n, 1'b0);
                  end else begin
                     r.status = pat_pkg::STAT_ILLEGAL;
                  end
               end
            end
         end
         pat_pkg::OP_DISCARD: begin
            // The range is clipped at the end of the map.
            stop = it.page_index + it.page_count;
            if (stop > pat_pkg::PAGE_COUNT)
               stop = pat_pkg::PAGE_COUNT;
            for (p = it.page_index; p < stop; p++)
               page_map[MAP_RCV][p] = 1'b0;
         end
         default: begin
            if (advise_on)
               page_map[MAP_RCV][it.page_index] = 1'b1;
         end
      endcase
      return r;
   endfunction

   // Offer one item, starting at a falling edge, and predict it once accepted.
   // Valid is left high so that the next item follows without a bubble.
   task automatic send_item(input logic [1:0] op, input int unsigned idx,
                            input logic [1:0] exp_st, input logic [1:0] nxt_st,
                            input int unsigned cnt);
      page_req_type it;
      it.opcode = op;
      it.page_index = pat_pkg::page_type'(idx);
      it.match_state = exp_st;
      it.target_state = nxt_st;
      it.page_count = pat_pkg::CNT_W'(cnt);
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_ch.opcode = it.opcode;
      req_ch.page_index = it.page_index;
      req_ch.match_state = it.match_state;
      req_ch.target_state = it.target_state;
      req_ch.page_count = it.page_count;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      replies_due.push_back(track_page_item(it));
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering items and wait until every predicted result has come.
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (replies_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [pat_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pat_pkg::CSR_DATA_W-1:0] value);
      req_ch.valid = 1'b0;
      csr_ch.index = idx;
      csr_ch.data = value;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == pat_pkg::CSR_GROUP_SHIFT)
         grp_shift = value[2:0];
      else if (idx == pat_pkg::CSR_ADVISE_MODE)
         advise_on = value[0];
      csr_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Register writes with random upper bits, which the block must ignore.
   task automatic set_registers(input int shift, input int adv);
      logic [pat_pkg::CSR_DATA_W-1:0] d;
      wait_drained();
      d = pat_pkg::CSR_DATA_W'($urandom_range(255));
      d[2:0] = shift[2:0];
      write_csr(pat_pkg::CSR_GROUP_SHIFT, d);
      d = pat_pkg::CSR_DATA_W'($urandom_range(255));
      d[0] = adv[0];
      write_csr(pat_pkg::CSR_ADVISE_MODE, d);
   endtask

   // One random item: most often an aligned state change that follows the group's
   // present state, and mostly inside a hot window so groups are revisited.
   task automatic send_random_item();
      int unsigned n;
      int unsigned pick;
      int unsigned idx;
      int unsigned cnt;
      logic [1:0]  op;
      logic [1:0]  exp_st;
      logic [1:0]  nxt_st;
      logic [1:0]  st;
      logic [1:0]  stat;
      n = group_pages();
      pick = $urandom_range(99);
      if (pick < 25)
         op = pat_pkg::OP_GET;
      else if (pick < 70)
         op = pat_pkg::OP_CHANGE;
      else if (pick < 82)
         op = pat_pkg::OP_DISCARD;
      else
         op = pat_pkg::OP_EARLY;
      idx = ($urandom_range(99) < 85) ? hot_base + $urandom_range(1023) : $urandom_range(65535);
      if ((op == pat_pkg::OP_GET || op == pat_pkg::OP_CHANGE) && $urandom_range(99) < 88)
         idx = idx & ~(n - 1);
      exp_st = 2'($urandom_range(3));
      nxt_st = 2'($urandom_range(3));
      if (op == pat_pkg::OP_CHANGE && $urandom_range(99) < 75) begin
         read_group(idx, n, st, stat);
         exp_st = st;
         if (st == pat_pkg::ST_MISSING && $urandom_range(99) < 60)
            nxt_st = pat_pkg::ST_REQUESTED;
         else if (st != pat_pkg::ST_RECEIVED && $urandom_range(99) < 80)
            nxt_st = pat_pkg::ST_RECEIVED;
      end
      pick = $urandom_range(99);
      if (pick < 80)
         cnt = $urandom_range(200);
      else if (pick < 97)
         cnt = $urandom_range(4096);
      else
         cnt = $urandom_range(65536);
      send_item(op, idx, exp_st, nxt_st, cnt);
   endtask

   // Both maps read as missing after reset, at both ends of the map.
   task automatic test_reset_state();
      set_registers(0, 0);
      send_item(pat_pkg::OP_GET, 0, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_GET, 65535, pat_pkg::ST_RECEIVED, pat_pkg::ST_RECEIVED, 131071);
   endtask

   // Transitions on single pages, legal and illegal, and expectation misses.
   task automatic test_state_changes();
      send_item(pat_pkg::OP_CHANGE, 10, pat_pkg::ST_MISSING, pat_pkg::ST_REQUESTED, 0);
      send_item(pat_pkg::OP_CHANGE, 10, pat_pkg::ST_MISSING, pat_pkg::ST_RECEIVED, 0);
      send_item(pat_pkg::OP_CHANGE, 10, pat_pkg::ST_REQUESTED, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_CHANGE, 10, pat_pkg::ST_REQUESTED, pat_pkg::ST_RECEIVED, 0);
      send_item(pat_pkg::OP_CHANGE, 10, pat_pkg::ST_RECEIVED, pat_pkg::ST_RECEIVED, 0);
      send_item(pat_pkg::OP_CHANGE, 11, pat_pkg::ST_MISSING, pat_pkg::ST_RECEIVED, 0);
      send_item(pat_pkg::OP_CHANGE, 12, 2'd3, pat_pkg::ST_REQUESTED, 0);
      send_item(pat_pkg::OP_CHANGE, 12, pat_pkg::ST_MISSING, 2'd3, 0);
   endtask

   // Groups: misalignment, partly set groups, discards, early receive and the
   // saturated group shift.
   task automatic test_group_rules();
      set_registers(3, 1);
      write_csr(CSR_UNUSED, pat_pkg::CSR_DATA_W'($urandom_range(255)));
      send_item(pat_pkg::OP_GET, 8, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_GET, 4, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_CHANGE, 16, pat_pkg::ST_MISSING, pat_pkg::ST_REQUESTED, 0);
      // A received bit inside a requested group leaves bits set in both maps.
      send_item(pat_pkg::OP_EARLY, 19, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_GET, 16, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_DISCARD, 16, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 8);
      send_item(pat_pkg::OP_GET, 16, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_DISCARD, 65500, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 65536);
      send_item(pat_pkg::OP_EARLY, 65535, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_DISCARD, 0, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      set_registers(7, 0);
      send_item(pat_pkg::OP_EARLY, 32, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_GET, 32, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_GET, 65472, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
      send_item(pat_pkg::OP_DISCARD, 0, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 65536);
      send_item(pat_pkg::OP_GET, 0, pat_pkg::ST_MISSING, pat_pkg::ST_MISSING, 0);
   endtask

   // Random items under one register setting.
   task automatic test_random_mix(input int shift, input int adv, input bit quiet);
      set_registers(shift, adv);
      hot_base = $urandom_range(63) * 1024;
      req_idle_pct = quiet ? 0 : 27;
      rsp_idle_pct = quiet ? 0 : 27;
      repeat (ITEMS_PER_PHASE) send_random_item();
      req_idle_pct = 27;
      rsp_idle_pct = 27;
   endtask

   // The receiver holds off while items keep coming, so the block fills up and
   // stalls its input; then the sender waits for every result.
   task automatic test_backpressure();
      set_registers(2, 1);
      hot_base = $urandom_range(63) * 1024;
      req_idle_pct = 0;
      hold_left = 300;
      repeat (30) send_random_item();
      wait_drained();
      req_idle_pct = 27;
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = pat_pkg::OP_GET;
      req_ch.page_index = '0;
      req_ch.match_state = pat_pkg::ST_MISSING;
      req_ch.target_state = pat_pkg::ST_MISSING;
      req_ch.page_count = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = pat_pkg::CSR_GROUP_SHIFT;
      csr_ch.data = '0;
      grp_shift = 3'd0;
      advise_on = 1'b0;
      mismatch_count = 0;
      items_sent = 0;
      results_seen = 0;
      csr_writes = 0;
      cycle_count = 0;
      req_idle_pct = 27;
      rsp_idle_pct = 27;
      hold_left = 0;
      hot_base = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_state_changes();
      test_group_rules();
      for (int ph = 0; ph < PHASES; ph++)
         test_random_mix(SHIFT_PLAN[ph], ADVISE_PLAN[ph], ph == QUIET_PHASE);
      test_backpressure();

      wait_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d items and checked %0d results over %0d register writes.",
               items_sent, results_seen, csr_writes);
      $display("Group shifts 0 to 7, both advise settings, stalls and a long hold-off;");
      $display("%0d mismatches.", mismatch_count);
      if (mismatch_count == 0 && replies_due.size() == 0)
         $display("[page_arrival_state_tracker] OK");
      else
         $display("[page_arrival_state_tracker] ERROR");
      $finish;
   end

endmodule

// File: files.f
hdl/pat_pkg.sv
hdl/pat_channels.sv
hdl/page_arrival_state_tracker.sv
tb/tb.sv
